// File: hw/rtl/tce_pkg.sv
// ----------------------------------------------------------------------------
// tce_pkg
// shared widths, codes and helpers of the trigraph contraction engine
// ----------------------------------------------------------------------------
package tce_pkg;

  localparam int NUM_VERTICES = 64;
  localparam int IDX_W        = $clog2(NUM_VERTICES);
  localparam int ADDR_W       = 2 * IDX_W;
  localparam int CNT_W        = 6;

  typedef enum logic [1:0] {
    COL_NONE  = 2'd0,
    COL_BLACK = 2'd1,
    COL_RED   = 2'd2
  } colour_e;

  localparam logic [1:0] ACT_ADD      = 2'd0;
  localparam logic [1:0] ACT_CONTRACT = 2'd1;
  localparam logic [1:0] ACT_QUERY    = 2'd2;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    colour_e           data;
  } edge_wr_t;

  // unordered pair, smaller index in the upper bits
  function automatic logic [ADDR_W-1:0] pair_addr(logic [IDX_W-1:0] x, logic [IDX_W-1:0] y);
    logic [ADDR_W-1:0] r;
    r = (x < y) ? {x, y} : {y, x};
    return r;
  endfunction

endpackage

// File: hw/rtl/tce_edge_store.sv
// ----------------------------------------------------------------------------
// tce_edge_store
// pair colour memory: two registered reads, one write, clearing sweep at reset
// ----------------------------------------------------------------------------
module tce_edge_store (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [tce_pkg::ADDR_W-1:0]  rd_addr0_i,
  input  logic [tce_pkg::ADDR_W-1:0]  rd_addr1_i,
  output tce_pkg::colour_e            rd_data0_o,
  output tce_pkg::colour_e            rd_data1_o,
  input  tce_pkg::edge_wr_t           wr_i,
  output logic                        ready_o
);

  localparam int Depth = 2 ** tce_pkg::ADDR_W;

  tce_pkg::colour_e            mem_q [Depth];
  tce_pkg::colour_e            rd0_q, rd1_q;
  logic [tce_pkg::ADDR_W-1:0]  clr_q;
  logic                        busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      busy_q <= 1'b1;
    end else if (busy_q) begin
      clr_q <= clr_q + 1'b1;
      if (&clr_q) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem_q[clr_q] <= tce_pkg::COL_NONE;
    end else if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rd0_q <= mem_q[rd_addr0_i];
    rd1_q <= mem_q[rd_addr1_i];
  end

  assign rd_data0_o = rd0_q;
  assign rd_data1_o = rd1_q;
  assign ready_o    = !busy_q;

endmodule

// File: hw/rtl/trigraph_contraction_engine.sv
// ----------------------------------------------------------------------------
// trigraph_contraction_engine
// trigraph store with black edge insert, vertex contraction and cost query
// ----------------------------------------------------------------------------
//  channel  | direction | tdata                          | tuser
//  s_axis   | in        | [5:0] vertex_a, [11:6] vertex_b | [1:0] action
//  m_axis   | out       | [5:0] max_red_degree            | [0] status
//
//  contract and query step through every vertex: a read of both pairs, then a
//  colour write and a clear write through the edge memory write port; a query
//  only reads and writes nothing
//  after reset every edge memory entry is cleared with s_axis_tready low
//  a new beat is taken while a finished result still waits on m_axis; the next
//  result then holds the engine until that beat leaves
module trigraph_contraction_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [5:0] vertex_a, [11:6] vertex_b
  input  logic [1:0]  s_axis_tuser,   // [1:0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [5:0] max_red_degree
  output logic        m_axis_tuser    // [0] status
);

  localparam int NV = tce_pkg::NUM_VERTICES;
  localparam int IW = tce_pkg::IDX_W;
  localparam int CW = tce_pkg::CNT_W;

  localparam logic [3:0] ST_CLR    = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_ADD_RD = 4'd2;
  localparam logic [3:0] ST_ADD_WR = 4'd3;
  localparam logic [3:0] ST_C_RD   = 4'd4;
  localparam logic [3:0] ST_C_W1   = 4'd5;
  localparam logic [3:0] ST_C_W2   = 4'd6;
  localparam logic [3:0] ST_FIN1   = 4'd7;
  localparam logic [3:0] ST_FIN2   = 4'd8;
  localparam logic [3:0] ST_DONE   = 4'd9;

  logic [3:0]     state_q;
  logic [IW-1:0]  a_q, b_q, v_q;
  logic           commit_q;
  logic [CW-1:0]  cnt_a_q, peak_w_q, peak_q, res_q;
  logic           rej_q;
  logic [NV-1:0]  alive_q;
  logic           out_valid_q, out_stat_q;
  logic [CW-1:0]  out_data_q;
  logic           out_load;

  logic [IW-1:0]  in_a, in_b;
  logic           in_acc, in_ok;

  tce_pkg::colour_e           ea, eb, nc;
  tce_pkg::edge_wr_t          ewr;
  logic [tce_pkg::ADDR_W-1:0] rd_addr0, rd_addr1;
  logic                       store_ready;

  logic [CW-1:0]  red_mem_q [NV];
  logic [NV-1:0]  red_vld_q;
  logic [CW-1:0]  red_rd_q;
  logic           red_rd_vld_q;
  logic [CW-1:0]  red_val, cnt_new;
  logic           red_we;
  logic [IW-1:0]  red_waddr;
  logic [CW-1:0]  red_wdata;
  logic           skip;

  assign in_a   = s_axis_tdata[IW-1:0];
  assign in_b   = s_axis_tdata[2*IW-1:IW];
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign in_ok  = (in_a != in_b)
               && ({1'b0, in_a} < (IW+1)'(NV)) && ({1'b0, in_b} < (IW+1)'(NV))
               && alive_q[in_a] && alive_q[in_b];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign out_load      = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);

  tce_edge_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_addr0_i (rd_addr0),
    .rd_addr1_i (rd_addr1),
    .rd_data0_o (ea),
    .rd_data1_o (eb),
    .wr_i       (ewr),
    .ready_o    (store_ready)
  );

  assign rd_addr0 = (state_q == ST_C_RD) ? tce_pkg::pair_addr(a_q, v_q)
                                         : tce_pkg::pair_addr(a_q, b_q);
  assign rd_addr1 = tce_pkg::pair_addr(b_q, v_q);

  assign skip    = (v_q == a_q) || (v_q == b_q) || !alive_q[v_q];
  assign red_val = red_rd_vld_q ? red_rd_q : '0;

  always_comb begin
    if (ea == tce_pkg::COL_NONE && eb == tce_pkg::COL_NONE) begin
      nc = tce_pkg::COL_NONE;
    end else if (ea == tce_pkg::COL_BLACK && eb == tce_pkg::COL_BLACK) begin
      nc = tce_pkg::COL_BLACK;
    end else begin
      nc = tce_pkg::COL_RED;
    end
    cnt_new = red_val - CW'(ea == tce_pkg::COL_RED) - CW'(eb == tce_pkg::COL_RED)
            + CW'(nc == tce_pkg::COL_RED);
  end

  always_comb begin
    ewr       = '0;
    red_we    = 1'b0;
    red_waddr = v_q;
    red_wdata = cnt_new;
    unique case (state_q)
      ST_ADD_WR: begin
        ewr.en   = (ea == tce_pkg::COL_NONE);
        ewr.addr = tce_pkg::pair_addr(a_q, b_q);
        ewr.data = tce_pkg::COL_BLACK;
      end
      ST_C_W1: begin
        ewr.en   = commit_q && !skip;
        ewr.addr = tce_pkg::pair_addr(a_q, v_q);
        ewr.data = nc;
        red_we   = commit_q && !skip;
      end
      ST_C_W2: begin
        ewr.en   = commit_q && !skip;
        ewr.addr = tce_pkg::pair_addr(b_q, v_q);
        ewr.data = tce_pkg::COL_NONE;
      end
      ST_FIN1: begin
        ewr.en    = commit_q;
        ewr.addr  = tce_pkg::pair_addr(a_q, b_q);
        ewr.data  = tce_pkg::COL_NONE;
        red_we    = commit_q;
        red_waddr = a_q;
        red_wdata = cnt_a_q;
      end
      ST_FIN2: begin
        red_we    = 1'b1;
        red_waddr = b_q;
        red_wdata = '0;
      end
      default: begin
      end
    endcase
  end

  // red degree memory, entries without a valid bit read as zero
  always_ff @(posedge clk_i) begin
    if (red_we) begin
      red_mem_q[red_waddr] <= red_wdata;
    end
    red_rd_q <= red_mem_q[v_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_vld_q    <= '0;
      red_rd_vld_q <= 1'b0;
    end else begin
      if (red_we) begin
        red_vld_q[red_waddr] <= 1'b1;
      end
      red_rd_vld_q <= red_vld_q[v_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      alive_q     <= '1;
      peak_q      <= '0;
      a_q         <= '0;
      b_q         <= '0;
      v_q         <= '0;
      commit_q    <= 1'b0;
      cnt_a_q     <= '0;
      peak_w_q    <= '0;
      res_q       <= '0;
      rej_q       <= 1'b0;
    end else begin
      unique case (state_q)
        ST_CLR: begin
          if (store_ready) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            a_q      <= in_a;
            b_q      <= in_b;
            v_q      <= '0;
            cnt_a_q  <= '0;
            peak_w_q <= peak_q;
            res_q    <= peak_q;
            commit_q <= (s_axis_tuser == tce_pkg::ACT_CONTRACT);
            if (!in_ok) begin
              rej_q   <= 1'b1;
              state_q <= ST_DONE;
            end else begin
              case (s_axis_tuser) inside
                tce_pkg::ACT_ADD: begin
                  rej_q   <= 1'b0;
                  state_q <= ST_ADD_RD;
                end
                tce_pkg::ACT_CONTRACT, tce_pkg::ACT_QUERY: begin
                  rej_q   <= 1'b0;
                  state_q <= ST_C_RD;
                end
                default: begin
                  rej_q   <= 1'b1;
                  state_q <= ST_DONE;
                end
              endcase
            end
          end
        end
        ST_ADD_RD: state_q <= ST_ADD_WR;
        ST_ADD_WR: state_q <= ST_DONE;
        ST_C_RD:   state_q <= ST_C_W1;
        ST_C_W1: begin
          if (!skip) begin
            cnt_a_q <= cnt_a_q + CW'(nc == tce_pkg::COL_RED);
            if (nc != tce_pkg::COL_NONE && cnt_new > peak_w_q) begin
              peak_w_q <= cnt_new;
            end
          end
          state_q <= ST_C_W2;
        end
        ST_C_W2: begin
          v_q <= v_q + 1'b1;
          state_q <= (v_q == IW'(NV - 1)) ? ST_FIN1 : ST_C_RD;
        end
        ST_FIN1: begin
          res_q   <= (cnt_a_q > peak_w_q) ? cnt_a_q : peak_w_q;
          state_q <= commit_q ? ST_FIN2 : ST_DONE;
        end
        ST_FIN2: begin
          alive_q[b_q] <= 1'b0;
          peak_q       <= res_q;
          state_q      <= ST_DONE;
        end
        ST_DONE: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= res_q;
      out_stat_q <= rej_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(8 - CW)'(0), out_data_q};
  assign m_axis_tuser  = out_stat_q;

endmodule

// File: hw/rtl/tce_checker.sv
// ----------------------------------------------------------------------------
// tce_checker
// port level checks of the trigraph contraction engine
// ----------------------------------------------------------------------------
module tce_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [15:0] s_axis_tdata,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        m_axis_tuser
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // one item at a time
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while busy");

  // no result appears right after an input beat
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result too early");

endmodule

bind trigraph_contraction_engine tce_checker u_tce_checker (.*);

// File: verif/trigraph_contraction_engine_checker.sv
// ----------------------------------------------------------------------------
// trigraph_contraction_engine_checker
// watches both stream channels, predicts each result from a private copy of
// the trigraph state and compares it field by field with the output beats
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module trigraph_contraction_engine_checker
  import tce_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,
  input  logic        m_axis_tuser,
  output int          fail_count_o,
  output int          pending_o,
  output int          result_count_o,
  output int          merge_count_o,
  output int          reject_count_o
);

  typedef struct packed {
    logic [CNT_W-1:0] peak;
    logic             rejected;
  } outcome_t;

  colour_e          colour_q [NUM_VERTICES][NUM_VERTICES];
  logic             alive_q  [NUM_VERTICES];
  logic [CNT_W-1:0] red_deg_q[NUM_VERTICES];
  logic [CNT_W-1:0] peak_q;
  outcome_t         outcome_fifo[$];

  assign pending_o = outcome_fifo.size();

  function automatic colour_e merge_colour(colour_e ea, colour_e eb);
    if (ea == COL_NONE && eb == COL_NONE) return COL_NONE;
    if (ea == COL_BLACK && eb == COL_BLACK) return COL_BLACK;
    return COL_RED;
  endfunction

  // walks a contraction of b into a, applying it when commit is set
  function automatic logic [CNT_W-1:0] merge_vertices(int a, int b, bit commit);
    int      peak;
    int      deg_a;
    int      cnt;
    colour_e ea, eb, nc;
    peak  = int'(peak_q);
    deg_a = 0;
    for (int v = 0; v < NUM_VERTICES; v++) begin
      if (v == a || v == b || !alive_q[v]) continue;
      ea  = colour_q[a][v];
      eb  = colour_q[b][v];
      nc  = merge_colour(ea, eb);
      cnt = int'(red_deg_q[v]) - int'(ea == COL_RED) - int'(eb == COL_RED)
          + int'(nc == COL_RED);
      cnt = cnt & 63;
      if (nc == COL_RED) deg_a++;
      if (nc != COL_NONE && cnt > peak) peak = cnt;
      if (commit) begin
        red_deg_q[v] = cnt[CNT_W-1:0];
        colour_q[a][v] = nc; colour_q[v][a] = nc;
        colour_q[b][v] = COL_NONE; colour_q[v][b] = COL_NONE;
      end
    end
    deg_a = deg_a & 63;
    if (deg_a > peak) peak = deg_a;
    if (commit) begin
      colour_q[a][b] = COL_NONE; colour_q[b][a] = COL_NONE;
      red_deg_q[a] = deg_a[CNT_W-1:0];
      red_deg_q[b] = '0;
      alive_q[b] = 1'b0;
      peak_q = peak[CNT_W-1:0];
    end
    return peak[CNT_W-1:0];
  endfunction

  function automatic outcome_t apply_beat(logic [1:0] act, int a, int b);
    outcome_t r;
    bit       ok;
    r.peak = peak_q;
    r.rejected = 1'b1;
    ok = (a != b) && alive_q[a] && alive_q[b];
    if (ok && act == ACT_ADD) begin
      if (colour_q[a][b] == COL_NONE) begin
        colour_q[a][b] = COL_BLACK; colour_q[b][a] = COL_BLACK;
      end
      r.rejected = 1'b0;
    end else if (ok && act == ACT_CONTRACT) begin
      r.peak = merge_vertices(a, b, 1'b1);
      r.rejected = 1'b0;
      merge_count_o++;
    end else if (ok && act == ACT_QUERY) begin
      r.peak = merge_vertices(a, b, 1'b0);
      r.rejected = 1'b0;
    end
    if (r.rejected) reject_count_o++;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t got, want;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_VERTICES; i++) begin
        alive_q[i] = 1'b1;
        red_deg_q[i] = '0;
        for (int j = 0; j < NUM_VERTICES; j++) colour_q[i][j] = COL_NONE;
      end
      peak_q = '0;
      outcome_fifo.delete();
      fail_count_o = 0;
      result_count_o = 0;
      merge_count_o = 0;
      reject_count_o = 0;
    end else begin
      // output first: a result never stems from the beat taken at this edge
      if (m_axis_tvalid && m_axis_tready) begin
        got.peak = m_axis_tdata[CNT_W-1:0];
        got.rejected = m_axis_tuser;
        result_count_o++;
        if (outcome_fifo.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("%0t: unexpected result beat peak=%0d status=%0b",
                     $time, got.peak, got.rejected);
        end else begin
          want = outcome_fifo.pop_front();
          if (got.peak !== want.peak || got.rejected !== want.rejected
              || m_axis_tdata[7:CNT_W] !== '0) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("%0t: mismatch peak exp %0d got %0d, status exp %0b got %0b",
                       $time, want.peak, got.peak, want.rejected, got.rejected);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        outcome_fifo = {outcome_fifo, apply_beat(s_axis_tuser, int'(s_axis_tdata[5:0]),
                                                 int'(s_axis_tdata[11:6]))};
    end
  end

endmodule

// File: verif/trigraph_contraction_engine_test.sv
// ----------------------------------------------------------------------------
// trigraph_contraction_engine_test
// drives directed and random add, contract and query beats through the engine
// under several idle and stall patterns; a checker predicts every result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module trigraph_contraction_engine_test;
  import tce_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tuser;

  int fail_count, pending, result_count, merge_count, reject_count;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cycle_count = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  trigraph_contraction_engine uut (.*);

  trigraph_contraction_engine_checker checker_inst (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .fail_count_o(fail_count), .pending_o(pending), .result_count_o(result_count),
    .merge_count_o(merge_count), .reject_count_o(reject_count)
  );

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("trigraph_contraction_engine regression: fail");
      $finish;
    end
  end

  // tready only moves at the rising edge, so its value at the falling edge
  // decides whether the next rising edge takes the beat
  task automatic send_beat(logic [1:0] act, logic [5:0] a, logic [5:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {4'b0, b, a};
    while (!s_axis_tready) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // mostly vertices in a small window so contractions build red edges
  task automatic random_beats(int count, int window);
    logic [1:0] act;
    logic [5:0] a, b;
    for (int i = 0; i < count; i++) begin
      a = 6'($urandom_range(window - 1));
      b = 6'($urandom_range(window - 1));
      case ($urandom_range(9))
        0, 1, 2, 3, 4: act = ACT_ADD;
        5, 6:          act = ACT_CONTRACT;
        7, 8:          act = ACT_QUERY;
        default: begin
          act = 2'($urandom_range(3));
          a = 6'($urandom); b = 6'($urandom);
        end
      endcase
      send_beat(act, a, b);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extremes, every action, rejections, duplicate add
    send_beat(ACT_ADD, 6'd0, 6'd63);
    send_beat(ACT_ADD, 6'd63, 6'd0);
    send_beat(ACT_ADD, 6'd0, 6'd1);
    send_beat(ACT_ADD, 6'd63, 6'd2);
    send_beat(ACT_ADD, 6'd1, 6'd2);
    send_beat(ACT_ADD, 6'd5, 6'd5);
    send_beat(2'd3, 6'd3, 6'd4);
    send_beat(ACT_QUERY, 6'd0, 6'd63);
    send_beat(ACT_QUERY, 6'd7, 6'd7);
    send_beat(ACT_CONTRACT, 6'd0, 6'd63);
    send_beat(ACT_ADD, 6'd0, 6'd63);
    send_beat(ACT_ADD, 6'd0, 6'd2);
    send_beat(ACT_QUERY, 6'd2, 6'd63);
    send_beat(ACT_CONTRACT, 6'd63, 6'd0);
    send_beat(ACT_CONTRACT, 6'd1, 6'd0);
    send_beat(ACT_QUERY, 6'd1, 6'd42);
    send_beat(ACT_CONTRACT, 6'd42, 6'd21);
    drain_results();

    // no idling, sender idle, receiver stalling, both
    random_beats(250, 64);
    drain_results();
    send_idle_pct = 74;
    random_beats(200, 32);
    send_idle_pct = 0;
    recv_stall_pct = 74;
    random_beats(200, 24);
    send_idle_pct = 9;
    recv_stall_pct = 9;
    random_beats(250, 16);

    drain_results();
    recv_stall_pct = 0;
    repeat (300) @(negedge clk_i);

    $display("covered %0d results, %0d contractions and %0d rejections",
             result_count, merge_count, reject_count);
    if (fail_count == 0 && pending == 0)
      $display("trigraph_contraction_engine regression: pass");
    else
      $display("trigraph_contraction_engine regression: fail");
    $finish;
  end

endmodule
